// ===== sv/idtp_pkg.sv =====
package idtp_pkg;

  // Character codes of the date-time syntax.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;

  // Field widths and saturation limits.
  localparam int YEAR_W  = 21;
  localparam int FIELD_W = 15;
  localparam int ACC_W   = 20;
  localparam logic [ACC_W-1:0] YEAR_LIMIT  = 20'd999999;
  localparam logic [ACC_W-1:0] FIELD_LIMIT = 20'd9999;

  // Year magnitude is tracked modulo 400 for the leap rule.
  localparam int MOD_W = 9;
  localparam logic [MOD_W-1:0] YEAR_LIMIT_MOD = 9'd399;

  // Range limits of the time fields.
  localparam logic [13:0] HOUR_MAX = 14'd23;
  localparam logic [13:0] MIN_MAX  = 14'd59;
  localparam logic [13:0] MONTH_MAX = 14'd12;

  typedef enum logic [2:0] {
    PH_YEAR,
    PH_MONTH,
    PH_DAY,
    PH_HOUR,
    PH_MINUTE,
    PH_SECOND,
    PH_DONE_OK,
    PH_DONE_FAIL
  } phase_t;

  // Fields of a finished string, handed from the parser to the checker.
  typedef struct packed {
    logic                       done;
    logic                       ok;
    logic                       leap;
    logic signed [YEAR_W-1:0]   year;
    logic signed [FIELD_W-1:0]  month;
    logic signed [FIELD_W-1:0]  day;
    logic signed [FIELD_W-1:0]  hour;
    logic signed [FIELD_W-1:0]  minute;
    logic signed [FIELD_W-1:0]  second;
  } fields_t;

  // One decimal step of the year magnitude modulo 400: (r * 10 + d) mod 400.
  function automatic logic [MOD_W-1:0] mod400_step(logic [MOD_W-1:0] r, logic [3:0] d);
    logic [11:0] x;
    logic [3:0]  q;
    x = ({3'b000, r} << 3) + ({3'b000, r} << 1) + {8'h00, d};
    q = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (x >= 12'(k * 400)) begin
        q = 4'(k);
      end
    end
    return MOD_W'(x - 12'(q) * 12'd400);
  endfunction

  // Gregorian leap rule from the magnitude modulo 400.
  function automatic logic is_leap(logic [MOD_W-1:0] r);
    return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  // Days in a month (1 to 12); other codes give no valid day.
  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    logic [4:0] d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== sv/iso_date_time_parser.sv =====
// Date-time string parser, one character per item.
// Input channel: in_valid / in_ready with in_ch, one string byte per item.
// A zero byte ends the string and produces one result item on the output
// channel (out_valid / out_ready) with out_valid_res and the six fields;
// all other bytes produce no result.
// A byte is registered at the input and parsed from that register; the
// result of a zero byte is written to the output register at the end
// of its parse step, so a result passes through the input register and
// then the output register.
// Throughput: one byte per cycle while the output is not stalled; the
// limit is the single parse step per byte on the parser state register.
// When the receiver holds out_ready low with a result waiting, the parser
// stops and in_ready falls as soon as the input register is occupied; no
// byte or result is lost. After the result is taken the parser is back at
// the start of the year field.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of the year field with all fields at zero.
module iso_date_time_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_ch,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_valid_res,
  output logic signed [idtp_pkg::YEAR_W-1:0]  out_year,
  output logic signed [idtp_pkg::FIELD_W-1:0] out_month,
  output logic signed [idtp_pkg::FIELD_W-1:0] out_day,
  output logic signed [idtp_pkg::FIELD_W-1:0] out_hour,
  output logic signed [idtp_pkg::FIELD_W-1:0] out_minute,
  output logic signed [idtp_pkg::FIELD_W-1:0] out_second
);
  import idtp_pkg::*;

  fields_t                   res;
  logic                      chk_valid;
  logic                      adv;
  logic                      out_valid_r, out_valid_nxt;
  logic                      valid_res_r;
  logic signed [YEAR_W-1:0]  year_r;
  logic signed [FIELD_W-1:0] month_r, day_r, hour_r, minute_r, second_r;

  // The parser may step when the output register is empty or draining.
  assign adv = !out_valid_r || out_ready;

  idtp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .adv      (adv),
    .res      (res)
  );

  idtp_check u_check (
    .res       (res),
    .valid_res (chk_valid)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      valid_res_r <= chk_valid;
      year_r      <= res.year;
      month_r     <= res.month;
      day_r       <= res.day;
      hour_r      <= res.hour;
      minute_r    <= res.minute;
      second_r    <= res.second;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = valid_res_r;
  assign out_year      = year_r;
  assign out_month     = month_r;
  assign out_day       = day_r;
  assign out_hour      = hour_r;
  assign out_minute    = minute_r;
  assign out_second    = second_r;

  // A finished string always lands in the output register.
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |=> out_valid_r)
    else $error("finished string did not produce a result");

  // A result is only produced while the output register can take it.
  a_done_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> (!out_valid_r || out_ready))
    else $error("result produced over a stalled result");

  // A valid result has its month and hour in range.
  a_valid_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && valid_res_r) |->
      (!month_r[FIELD_W-1] && month_r[13:0] != 14'd0 && month_r[13:0] <= MONTH_MAX
       && !hour_r[FIELD_W-1] && hour_r[13:0] <= HOUR_MAX))
    else $error("valid result with month or hour out of range");

endmodule

// ===== sv/idtp_parser.sv =====
module idtp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_ch,
  input  logic              adv,
  output idtp_pkg::fields_t res
);
  import idtp_pkg::*;

  logic                      byte_vld_r, byte_vld_nxt;
  logic [7:0]                byte_r, byte_nxt;
  phase_t                    phase_r, phase_nxt, phase_upd;
  logic [ACC_W-1:0]          acc_r, acc_nxt, acc_upd;
  logic [MOD_W-1:0]          mod_r, mod_nxt, mod_upd;
  logic                      neg_r, neg_nxt, neg_upd;
  logic                      seen_r, seen_nxt, seen_upd;
  logic                      leap_r, leap_nxt, leap_upd;
  logic signed [YEAR_W-1:0]  year_r, year_nxt, year_upd;
  logic signed [FIELD_W-1:0] month_r, month_nxt, month_upd;
  logic signed [FIELD_W-1:0] day_r, day_nxt, day_upd;
  logic signed [FIELD_W-1:0] hour_r, hour_nxt, hour_upd;
  logic signed [FIELD_W-1:0] minute_r, minute_nxt, minute_upd;
  logic signed [FIELD_W-1:0] second_r, second_nxt, second_upd;

  logic                      proc;
  logic                      is_digit;
  logic [3:0]                digit;
  logic [23:0]               acc_sum;
  logic [ACC_W-1:0]          lim;
  logic signed [YEAR_W-1:0]  year_val;
  logic signed [FIELD_W-1:0] field_val;

  // The byte register advances whenever the result side can take a result.
  assign proc     = byte_vld_r && adv;
  assign in_ready = !byte_vld_r || adv;

  always_comb begin
    byte_nxt     = byte_r;
    byte_vld_nxt = byte_vld_r;
    if (in_valid && in_ready) begin
      byte_nxt     = in_ch;
      byte_vld_nxt = 1'b1;
    end else if (proc) begin
      byte_vld_nxt = 1'b0;
    end
  end

  // Digit accumulation with saturation.
  assign is_digit = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);
  assign digit    = 4'(byte_r - CH_ZERO);
  assign lim      = (phase_r == PH_YEAR) ? YEAR_LIMIT : FIELD_LIMIT;
  assign acc_sum  = ({4'h0, acc_r} << 3) + ({4'h0, acc_r} << 1) + {20'h00000, digit};

  // Signed value of the field that ends on this byte; zero without digits.
  assign year_val  = !seen_r ? '0 :
                     neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
  assign field_val = !seen_r ? '0 :
                     neg_r ? -$signed({1'b0, acc_r[13:0]}) : $signed({1'b0, acc_r[13:0]});

  // Parser state after the current byte.
  always_comb begin
    phase_upd  = phase_r;
    acc_upd    = acc_r;
    mod_upd    = mod_r;
    neg_upd    = neg_r;
    seen_upd   = seen_r;
    leap_upd   = leap_r;
    year_upd   = year_r;
    month_upd  = month_r;
    day_upd    = day_r;
    hour_upd   = hour_r;
    minute_upd = minute_r;
    second_upd = second_r;
    if (phase_r != PH_DONE_OK && phase_r != PH_DONE_FAIL) begin
      if (!neg_r && !seen_r && byte_r == CH_MINUS) begin
        neg_upd = 1'b1;
      end else if (is_digit) begin
        seen_upd = 1'b1;
        if (acc_sum > {4'h0, lim}) begin
          acc_upd = lim;
          mod_upd = YEAR_LIMIT_MOD;
        end else begin
          acc_upd = acc_sum[ACC_W-1:0];
          mod_upd = mod400_step(mod_r, digit);
        end
      end else begin
        // The field ends: store it and pick the next field.
        unique case (phase_r)
          PH_YEAR: begin
            year_upd = year_val;
            leap_upd = is_leap(mod_r);
          end
          PH_MONTH:  month_upd  = field_val;
          PH_DAY:    day_upd    = field_val;
          PH_HOUR:   hour_upd   = field_val;
          PH_MINUTE: minute_upd = field_val;
          default:   second_upd = field_val;
        endcase
        if (!seen_r) begin
          phase_upd = PH_DONE_FAIL;
        end else begin
          unique case (phase_r)
            PH_YEAR:   phase_upd = (byte_r == CH_MINUS) ? PH_MONTH : PH_DONE_FAIL;
            PH_MONTH:  phase_upd = (byte_r == CH_MINUS) ? PH_DAY : PH_DONE_FAIL;
            PH_DAY:    phase_upd = (byte_r == CH_SPACE || byte_r == CH_T) ? PH_HOUR
                                                                           : PH_DONE_OK;
            PH_HOUR:   phase_upd = (byte_r == CH_COLON) ? PH_MINUTE : PH_DONE_FAIL;
            PH_MINUTE: phase_upd = (byte_r == CH_COLON) ? PH_SECOND : PH_DONE_OK;
            default:   phase_upd = PH_DONE_OK;
          endcase
        end
        acc_upd  = '0;
        mod_upd  = '0;
        neg_upd  = 1'b0;
        seen_upd = 1'b0;
      end
    end
  end

  // A zero byte delivers the fields and returns the parser to its start.
  always_comb begin
    res.done   = proc && (byte_r == CH_NUL);
    res.ok     = (phase_upd == PH_DONE_OK);
    res.leap   = leap_upd;
    res.year   = year_upd;
    res.month  = month_upd;
    res.day    = day_upd;
    res.hour   = hour_upd;
    res.minute = minute_upd;
    res.second = second_upd;

    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    mod_nxt    = mod_r;
    neg_nxt    = neg_r;
    seen_nxt   = seen_r;
    leap_nxt   = leap_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    if (res.done) begin
      phase_nxt  = PH_YEAR;
      acc_nxt    = '0;
      mod_nxt    = '0;
      neg_nxt    = 1'b0;
      seen_nxt   = 1'b0;
      leap_nxt   = 1'b0;
      year_nxt   = '0;
      month_nxt  = '0;
      day_nxt    = '0;
      hour_nxt   = '0;
      minute_nxt = '0;
      second_nxt = '0;
    end else if (proc) begin
      phase_nxt  = phase_upd;
      acc_nxt    = acc_upd;
      mod_nxt    = mod_upd;
      neg_nxt    = neg_upd;
      seen_nxt   = seen_upd;
      leap_nxt   = leap_upd;
      year_nxt   = year_upd;
      month_nxt  = month_upd;
      day_nxt    = day_upd;
      hour_nxt   = hour_upd;
      minute_nxt = minute_upd;
      second_nxt = second_upd;
    end
  end

  // Byte register payload.
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  // Control and parse state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      phase_r    <= PH_YEAR;
      acc_r      <= '0;
      mod_r      <= '0;
      neg_r      <= 1'b0;
      seen_r     <= 1'b0;
      leap_r     <= 1'b0;
      year_r     <= '0;
      month_r    <= '0;
      day_r      <= '0;
      hour_r     <= '0;
      minute_r   <= '0;
      second_r   <= '0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      mod_r      <= mod_nxt;
      neg_r      <= neg_nxt;
      seen_r     <= seen_nxt;
      leap_r     <= leap_nxt;
      year_r     <= year_nxt;
      month_r    <= month_nxt;
      day_r      <= day_nxt;
      hour_r     <= hour_nxt;
      minute_r   <= minute_nxt;
      second_r   <= second_nxt;
    end
  end

endmodule

// ===== sv/idtp_check.sv =====
module idtp_check (
  input  idtp_pkg::fields_t res,
  output logic              valid_res
);
  import idtp_pkg::*;

  logic [4:0] dim;
  logic       month_ok;
  logic       day_ok;
  logic       time_ok;

  // Month 1 to 12, then the day against that month's length.
  assign month_ok = !res.month[FIELD_W-1] && (res.month[13:0] != 14'd0)
                    && (res.month[13:0] <= MONTH_MAX);
  assign dim      = month_days(res.month[3:0], res.leap);
  assign day_ok   = !res.day[FIELD_W-1] && (res.day[13:0] != 14'd0)
                    && (res.day[13:0] <= {9'h000, dim});

  // Hour 0 to 23, minute and second 0 to 59.
  assign time_ok = !res.hour[FIELD_W-1] && (res.hour[13:0] <= HOUR_MAX)
                   && !res.minute[FIELD_W-1] && (res.minute[13:0] <= MIN_MAX)
                   && !res.second[FIELD_W-1] && (res.second[13:0] <= MIN_MAX);

  assign valid_res = res.ok && month_ok && day_ok && time_ok;

endmodule
